[sv/bmp_rle_pkg.sv]
// ----------------------------------------------------------------------------
// bmp_rle_pkg
// shared types and constants of the bmp rle8 / rle4 span decoder
// ----------------------------------------------------------------------------
package bmp_rle_pkg;

    localparam int COORD_BITS_DEFAULT = 16;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FOUR_BIT_MODE = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BOTTOM_UP     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_ODD     = 3'd4;

    localparam logic [7:0] ESC_END_OF_LINE   = 8'd0;
    localparam logic [7:0] ESC_END_OF_BITMAP = 8'd1;
    localparam logic [7:0] ESC_DELTA         = 8'd2;

    localparam logic [3:0] NIBBLE_MASK  = 4'hF;
    localparam logic [7:0] ABS_NIBBLES  = 8'd2;

    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_RUN_INDEX,
        PH_ESCAPE,
        PH_DELTA_H,
        PH_DELTA_V,
        PH_ABS,
        PH_PAD,
        PH_DONE
    } phase_t;

endpackage

[sv/bmp_rle_span_decoder.sv]
// ----------------------------------------------------------------------------
// bmp_rle_span_decoder
// decodes a bmp rle8 / rle4 byte stream into clipped spans of palette indices
// ----------------------------------------------------------------------------
// result path: an accepted input transaction passes through the input register,
// then the result register
// throughput: one input byte per cycle unless a held result stalls it, set by the
// single parse stage that sits between the input register and the result register
// reset: synchronous active-low; parser in count phase, positions and error
// cleared, registers at defaults (bottom_up = 1, others 0)
// ----------------------------------------------------------------------------
module bmp_rle_span_decoder #(
    parameter int COORD_BITS = bmp_rle_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [bmp_rle_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bmp_rle_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [7:0]                             s_tdata,  // data_byte
    input  logic [0:0]                             s_tuser,  // cmd
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // image_row, start_col, pixel_count, index_even, index_odd
    output logic [55:0]                            m_tdata,
    // range_error, end_of_image
    output logic [1:0]                             m_tuser
);
    import bmp_rle_pkg::*;

    localparam int POS_BITS = COORD_BITS + 1;
    localparam int CMP_BITS = (POS_BITS > 16) ? POS_BITS : 16;
    localparam logic [15:0] OUT_MASK = (COORD_BITS >= 16) ? 16'hFFFF
                                     : 16'((32'd1 << COORD_BITS) - 32'd1);

    // configuration
    logic        four_bit_mode_reg;
    logic [15:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic        bottom_up_reg;
    logic        start_odd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            four_bit_mode_reg <= 1'b0;
            image_width_reg   <= 16'd0;
            image_height_reg  <= 16'd0;
            bottom_up_reg     <= 1'b1;
            start_odd_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FOUR_BIT_MODE: four_bit_mode_reg <= cfg_data[0];
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data;
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data;
                REG_BOTTOM_UP:     bottom_up_reg     <= cfg_data[0];
                REG_START_ODD:     start_odd_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       proc;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign proc     = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_cmd_reg  <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
    end

    // parser state
    phase_t              phase_reg, phase_next;
    logic [7:0]          run_length_reg, run_length_next;
    logic [7:0]          abs_left_reg, abs_left_next;
    logic [POS_BITS-1:0] row_pos_reg, row_pos_next;
    logic [POS_BITS-1:0] col_pos_reg, col_pos_next;
    logic                parity_reg, parity_next;
    logic [7:0]          delta_cols_reg, delta_cols_next;
    logic                err_reg, err_next;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [15:0] row_out_reg, row_out_next;
    logic [15:0] col_out_reg, col_out_next;
    logic [7:0]  cnt_out_reg, cnt_out_next;
    logic [7:0]  even_out_reg, even_out_next;
    logic [7:0]  odd_out_reg, odd_out_next;
    logic        eoi_out_reg, eoi_out_next;
    logic        err_out_reg;
    logic        load_out;

    // span datapath
    logic [7:0]          b;
    logic [7:0]          abs_n;
    logic [7:0]          span_n;
    logic [7:0]          idx_even;
    logic [7:0]          idx_odd;
    logic [CMP_BITS-1:0] row_ext;
    logic [CMP_BITS-1:0] col_ext;
    logic                in_image;
    logic [15:0]         avail;
    logic [7:0]          span_cnt;
    logic [15:0]         span_row;
    logic [7:0]          col_add;
    logic [7:0]          row_add;
    logic [POS_BITS:0]   col_sum;
    logic [POS_BITS:0]   row_sum;
    logic [POS_BITS-1:0] col_sat;
    logic [POS_BITS-1:0] row_sat;
    logic [7:0]          abs_left_dec;

    assign b        = in_byte_reg;
    assign abs_n    = !four_bit_mode_reg ? 8'd1
                    : ((abs_left_reg >= ABS_NIBBLES) ? ABS_NIBBLES : abs_left_reg);
    assign span_n   = (phase_reg == PH_RUN_INDEX) ? run_length_reg : abs_n;
    assign idx_even = four_bit_mode_reg ? {4'd0, b[7:4]} : b;
    assign idx_odd  = four_bit_mode_reg ? {4'd0, b[3:0] & NIBBLE_MASK} : b;
    assign row_ext  = CMP_BITS'(row_pos_reg);
    assign col_ext  = CMP_BITS'(col_pos_reg);
    assign in_image = (row_ext < CMP_BITS'(image_height_reg))
                   && (col_ext < CMP_BITS'(image_width_reg));
    assign avail    = image_width_reg - col_ext[15:0];
    assign span_cnt = ({8'd0, span_n} < avail) ? span_n : avail[7:0];
    assign span_row = (bottom_up_reg ? (image_height_reg - 16'd1 - row_ext[15:0])
                                     : row_ext[15:0]) & OUT_MASK;

    assign col_add  = (phase_reg == PH_DELTA_V) ? delta_cols_reg : span_n;
    assign row_add  = (phase_reg == PH_ESCAPE) ? 8'd1 : b;
    assign col_sum  = {1'b0, col_pos_reg} + (POS_BITS+1)'(col_add);
    assign row_sum  = {1'b0, row_pos_reg} + (POS_BITS+1)'(row_add);
    assign col_sat  = col_sum[POS_BITS] ? '1 : col_sum[POS_BITS-1:0];
    assign row_sat  = row_sum[POS_BITS] ? '1 : row_sum[POS_BITS-1:0];
    assign abs_left_dec = (abs_left_reg > abs_n) ? (abs_left_reg - abs_n) : 8'd0;

    always_comb begin
        phase_next      = phase_reg;
        run_length_next = run_length_reg;
        abs_left_next   = abs_left_reg;
        row_pos_next    = row_pos_reg;
        col_pos_next    = col_pos_reg;
        parity_next     = parity_reg;
        delta_cols_next = delta_cols_reg;
        err_next        = err_reg;
        load_out        = 1'b0;
        row_out_next    = 16'd0;
        col_out_next    = 16'd0;
        cnt_out_next    = 8'd0;
        even_out_next   = 8'd0;
        odd_out_next    = 8'd0;
        eoi_out_next    = 1'b0;

        if (proc) begin
            if (in_cmd_reg == CMD_START) begin
                phase_next      = PH_COUNT;
                run_length_next = 8'd0;
                abs_left_next   = 8'd0;
                row_pos_next    = '0;
                col_pos_next    = '0;
                parity_next     = start_odd_reg;
                delta_cols_next = 8'd0;
                err_next        = 1'b0;
            end else if (phase_reg != PH_DONE) begin
                parity_next = ~parity_reg;
                case (phase_reg)
                    PH_COUNT: begin
                        if (b == 8'd0) begin
                            phase_next = PH_ESCAPE;
                        end else begin
                            run_length_next = b;
                            phase_next      = PH_RUN_INDEX;
                        end
                    end
                    PH_RUN_INDEX, PH_ABS: begin
                        load_out      = 1'b1;
                        even_out_next = idx_even;
                        odd_out_next  = idx_odd;
                        col_pos_next  = col_sat;
                        if (in_image) begin
                            cnt_out_next = span_cnt;
                            row_out_next = span_row;
                            col_out_next = col_ext[15:0] & OUT_MASK;
                            if (span_cnt != span_n) begin
                                err_next = 1'b1;
                            end
                        end else begin
                            err_next = 1'b1;
                        end
                        if (phase_reg == PH_RUN_INDEX) begin
                            phase_next = PH_COUNT;
                        end else begin
                            abs_left_next = abs_left_dec;
                            if (abs_left_dec == 8'd0) begin
                                phase_next = parity_next ? PH_PAD : PH_COUNT;
                            end
                        end
                    end
                    PH_ESCAPE: begin
                        if (b == ESC_END_OF_LINE) begin
                            col_pos_next = '0;
                            row_pos_next = row_sat;
                            phase_next   = PH_COUNT;
                        end else if (b == ESC_END_OF_BITMAP) begin
                            load_out     = 1'b1;
                            eoi_out_next = 1'b1;
                            phase_next   = PH_DONE;
                        end else if (b == ESC_DELTA) begin
                            phase_next = PH_DELTA_H;
                        end else begin
                            abs_left_next = b;
                            phase_next    = PH_ABS;
                        end
                    end
                    PH_DELTA_H: begin
                        delta_cols_next = b;
                        phase_next      = PH_DELTA_V;
                    end
                    PH_DELTA_V: begin
                        col_pos_next = col_sat;
                        row_pos_next = row_sat;
                        phase_next   = PH_COUNT;
                    end
                    default: begin
                        phase_next = PH_COUNT;
                    end
                endcase
            end
        end

        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = load_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_COUNT;
            run_length_reg <= 8'd0;
            abs_left_reg   <= 8'd0;
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            parity_reg     <= 1'b0;
            delta_cols_reg <= 8'd0;
            err_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            run_length_reg <= run_length_next;
            abs_left_reg   <= abs_left_next;
            row_pos_reg    <= row_pos_next;
            col_pos_reg    <= col_pos_next;
            parity_reg     <= parity_next;
            delta_cols_reg <= delta_cols_next;
            err_reg        <= err_next;
            m_valid_reg    <= m_valid_next;
        end
        if (load_out) begin
            row_out_reg  <= row_out_next;
            col_out_reg  <= col_out_next;
            cnt_out_reg  <= cnt_out_next;
            even_out_reg <= even_out_next;
            odd_out_reg  <= odd_out_next;
            eoi_out_reg  <= eoi_out_next;
            err_out_reg  <= err_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {odd_out_reg, even_out_reg, cnt_out_reg, col_out_reg, row_out_reg};
    assign m_tuser  = {eoi_out_reg, err_out_reg};

    // error stays set until a start transaction
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg && !(proc && in_cmd_reg == CMD_START) |=> err_reg)
        else $error("error flag dropped without start");

    // end of bitmap holds until a start transaction
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DONE) && !(proc && in_cmd_reg == CMD_START)
        |=> (phase_reg == PH_DONE))
        else $error("left done phase without start");

    // end-of-bitmap result carries no pixels
    a_eoi_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && eoi_out_reg |-> (cnt_out_reg == 8'd0) && (row_out_reg == 16'd0))
        else $error("end of image result with pixels");

    // clipped span never exceeds the image width
    a_cnt_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (cnt_out_reg != 8'd0) |-> ({8'd0, cnt_out_reg} <= image_width_reg))
        else $error("span wider than image");

endmodule

[verif/bmp_rle_span_decoder_tb.sv]
// ----------------------------------------------------------------------------
// bmp_rle_span_decoder_tb
// self-checking bench for the bmp rle8 / rle4 span decoder: a queue-fed
// driver sends stream bytes and start commands in random bursts, an internal
// span predictor tracks parser state and positions, and a monitor compares
// every span transaction against the oldest prediction while the receiver
// stalls on a rotating pattern
// ----------------------------------------------------------------------------
module bmp_rle_span_decoder_tb;

    import bmp_rle_pkg::*;

    localparam int POS_BITS     = COORD_BITS_DEFAULT + 1;
    localparam int POS_LIMIT    = (1 << POS_BITS) - 1;
    localparam int RANDOM_ITEMS = 1200;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } stream_item_t;

    typedef struct packed {
        logic [15:0] row;
        logic [15:0] col;
        logic [7:0]  count;
        logic [7:0]  index_even;
        logic [7:0]  index_odd;
        logic        range_error;
        logic        end_of_image;
    } span_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata = '0;
    logic [0:0]                s_tuser = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [55:0]               m_tdata;
    logic [1:0]                m_tuser;

    bmp_rle_span_decoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // register copies
    logic        cfg_four_bit = 1'b0;
    logic [15:0] cfg_width = '0;
    logic [15:0] cfg_height = '0;
    logic        cfg_bottom_up = 1'b1;
    logic        cfg_start_odd = 1'b0;

    // predictor state
    phase_t                dec_phase = PH_COUNT;
    logic [7:0]            dec_run_len = '0;
    logic [7:0]            dec_abs_left = '0;
    logic [POS_BITS-1:0]   dec_row = '0;
    logic [POS_BITS-1:0]   dec_col = '0;
    logic                  dec_parity = 1'b0;
    logic [7:0]            dec_delta_cols = '0;
    logic                  dec_error = 1'b0;

    stream_item_t byte_q[$];
    span_t        span_q[$];
    stream_item_t cur_item;

    int mismatches = 0;
    int spans_checked = 0;
    int eoi_seen = 0;
    int error_spans = 0;
    int items_accepted = 0;
    int settings_used = 0;
    int random_items = 0;
    int cycle_cnt = 0;
    logic gen_parity = 1'b0;

    function automatic logic [POS_BITS-1:0] sat_pos(input logic [POS_BITS-1:0] a, input int b);
        int s;
        s = int'(a) + b;
        return (s > POS_LIMIT) ? POS_LIMIT[POS_BITS-1:0] : s[POS_BITS-1:0];
    endfunction

    task automatic clear_decoder();
        dec_phase = PH_COUNT;
        dec_run_len = '0;
        dec_abs_left = '0;
        dec_row = '0;
        dec_col = '0;
        dec_parity = cfg_start_odd;
        dec_delta_cols = '0;
        dec_error = 1'b0;
    endtask

    task automatic predict_span(input int n, input logic [7:0] ev, input logic [7:0] od);
        int    cnt;
        int    r;
        int    c;
        span_t s;
        cnt = 0;
        r = 0;
        c = 0;
        if (int'(dec_row) < int'(cfg_height) && int'(dec_col) < int'(cfg_width)) begin
            cnt = int'(cfg_width) - int'(dec_col);
            if (n < cnt) cnt = n;
            if (cnt < n) dec_error = 1'b1;
            r = cfg_bottom_up ? int'(cfg_height) - 1 - int'(dec_row) : int'(dec_row);
            c = int'(dec_col);
        end else begin
            dec_error = 1'b1;
        end
        dec_col = sat_pos(dec_col, n);
        s.row = r[15:0];
        s.col = c[15:0];
        s.count = cnt[7:0];
        s.index_even = ev;
        s.index_odd = od;
        s.range_error = dec_error;
        s.end_of_image = 1'b0;
        span_q.push_back(s);
    endtask

    task automatic decode_item(input stream_item_t it);
        int    n;
        span_t s;
        if (it.cmd == CMD_START) begin
            clear_decoder();
        end else if (dec_phase != PH_DONE) begin
            dec_parity = ~dec_parity;
            case (dec_phase)
                PH_COUNT: begin
                    if (it.data == 8'd0) begin
                        dec_phase = PH_ESCAPE;
                    end else begin
                        dec_run_len = it.data;
                        dec_phase = PH_RUN_INDEX;
                    end
                end
                PH_RUN_INDEX: begin
                    if (cfg_four_bit)
                        predict_span(dec_run_len, {4'h0, it.data[7:4]},
                                     {4'h0, it.data[3:0] & NIBBLE_MASK});
                    else
                        predict_span(dec_run_len, it.data, it.data);
                    dec_phase = PH_COUNT;
                end
                PH_ESCAPE: begin
                    if (it.data == ESC_END_OF_LINE) begin
                        dec_col = '0;
                        dec_row = sat_pos(dec_row, 1);
                        dec_phase = PH_COUNT;
                    end else if (it.data == ESC_END_OF_BITMAP) begin
                        s = '0;
                        s.range_error = dec_error;
                        s.end_of_image = 1'b1;
                        span_q.push_back(s);
                        dec_phase = PH_DONE;
                    end else if (it.data == ESC_DELTA) begin
                        dec_phase = PH_DELTA_H;
                    end else begin
                        dec_abs_left = it.data;
                        dec_phase = PH_ABS;
                    end
                end
                PH_DELTA_H: begin
                    dec_delta_cols = it.data;
                    dec_phase = PH_DELTA_V;
                end
                PH_DELTA_V: begin
                    dec_col = sat_pos(dec_col, dec_delta_cols);
                    dec_row = sat_pos(dec_row, it.data);
                    dec_phase = PH_COUNT;
                end
                PH_ABS: begin
                    if (cfg_four_bit) begin
                        n = (dec_abs_left >= ABS_NIBBLES) ? int'(ABS_NIBBLES) : int'(dec_abs_left);
                        predict_span(n, {4'h0, it.data[7:4]}, {4'h0, it.data[3:0] & NIBBLE_MASK});
                    end else begin
                        n = 1;
                        predict_span(n, it.data, it.data);
                    end
                    dec_abs_left = (int'(dec_abs_left) > n) ? dec_abs_left - n[7:0] : 8'd0;
                    if (dec_abs_left == 8'd0) dec_phase = dec_parity ? PH_PAD : PH_COUNT;
                end
                default: begin
                    dec_phase = PH_COUNT;
                end
            endcase
        end
    endtask

    // sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            clear_decoder();
        end else begin
            if (s_tvalid && s_tready) begin
                decode_item(cur_item);
                items_accepted++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    cur_item = byte_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= cur_item.data;
                    s_tuser <= cur_item.cmd;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: rotating stall pattern, reloaded now and then
    logic [15:0] stall_pat = 16'hFFFF;
    int          stall_tick = 0;

    always @(posedge aclk) begin
        m_tready <= stall_pat[0];
        if (stall_tick == 63) begin
            stall_tick <= 0;
            stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end else begin
            stall_tick <= stall_tick + 1;
            stall_pat <= {stall_pat[0], stall_pat[15:1]};
        end
    end

    task automatic check_field(input string fname, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("span %0d: %s expected %0d, got %0d", spans_checked, fname, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        span_t exp_s;
        span_t act_s;
        if (aresetn && m_tvalid && m_tready) begin
            act_s = {m_tdata[15:0], m_tdata[31:16], m_tdata[39:32], m_tdata[47:40],
                     m_tdata[55:48], m_tuser[0], m_tuser[1]};
            if (span_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected span transaction: %h %h", m_tdata, m_tuser);
            end else begin
                exp_s = span_q.pop_front();
                check_field("image_row", exp_s.row, act_s.row);
                check_field("start_col", exp_s.col, act_s.col);
                check_field("pixel_count", exp_s.count, act_s.count);
                check_field("index_even", exp_s.index_even, act_s.index_even);
                check_field("index_odd", exp_s.index_odd, act_s.index_odd);
                check_field("range_error", exp_s.range_error, act_s.range_error);
                check_field("end_of_image", exp_s.end_of_image, act_s.end_of_image);
                if (exp_s.end_of_image) eoi_seen++;
                if (exp_s.range_error) error_spans++;
            end
            spans_checked++;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout with %0d spans still expected", span_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus helpers
    task automatic push_byte(input logic [7:0] b, input bit counted);
        byte_q.push_back('{cmd: CMD_BYTE, data: b});
        gen_parity = ~gen_parity;
        if (counted) random_items++;
    endtask

    task automatic push_start();
        byte_q.push_back('{cmd: CMD_START, data: 8'($urandom)});
        gen_parity = cfg_start_odd;
        random_items++;
    endtask

    task automatic push_run(input int count, input logic [7:0] index);
        push_byte(count[7:0], 1);
        push_byte(index, 1);
    endtask

    task automatic push_escape(input logic [7:0] code);
        push_byte(8'd0, 1);
        push_byte(code, 1);
    endtask

    task automatic push_delta(input int dx, input int dy);
        push_escape(ESC_DELTA);
        push_byte(dx[7:0], 1);
        push_byte(dy[7:0], 1);
    endtask

    task automatic push_absolute(input int n);
        int nbytes;
        nbytes = cfg_four_bit ? (n + 1) / 2 : n;
        push_escape(n[7:0]);
        repeat (nbytes) push_byte(8'($urandom), 1);
        if (gen_parity) push_byte(8'($urandom), 1);
    endtask

    task automatic push_end_of_bitmap();
        push_escape(ESC_END_OF_BITMAP);
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 0);
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || s_tvalid || span_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_BITS-1:0];
        case (idx)
            REG_FOUR_BIT_MODE: cfg_four_bit = val[0];
            REG_IMAGE_WIDTH:   cfg_width = val[15:0];
            REG_IMAGE_HEIGHT:  cfg_height = val[15:0];
            REG_BOTTOM_UP:     cfg_bottom_up = val[0];
            REG_START_ODD:     cfg_start_odd = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(input int four, input int w, input int h, input int bu, input int so);
        wait_drained();
        write_reg(REG_FOUR_BIT_MODE, four);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_BOTTOM_UP, bu);
        write_reg(REG_START_ODD, so);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    function automatic int pick_dim(input int typical_max);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 0;
        if (r == 1) return 65535;
        if (r == 2) return $urandom_range(0, 65535);
        return $urandom_range(1, typical_max);
    endfunction

    task automatic random_image(input int n_ops);
        int op;
        push_start();
        for (int k = 0; k < n_ops; k++) begin
            op = $urandom_range(0, 99);
            if (op < 40) begin
                push_run(($urandom_range(0, 7) == 0) ? $urandom_range(1, 255)
                                                     : $urandom_range(1, 12), 8'($urandom));
            end else if (op < 55) begin
                push_escape(ESC_END_OF_LINE);
            end else if (op < 65) begin
                push_delta(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 6),
                           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 3));
            end else if (op < 90) begin
                push_absolute(($urandom_range(0, 9) == 0) ? $urandom_range(3, 255)
                                                          : $urandom_range(3, 14));
            end else if (op < 95) begin
                push_byte(8'($urandom), 1);
            end else if (op < 97) begin
                push_start();
            end else begin
                push_escape(8'($urandom));
            end
        end
        if ($urandom_range(0, 4) != 0) push_end_of_bitmap();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults, no start transaction: zero-sized image
        push_run(1, 8'h80);
        push_end_of_bitmap();
        push_start();

        // rle8: clipping at the right edge, line end, delta, padded absolute
        configure(0, 8, 4, 1, 0);
        push_start();
        push_run(3, 8'hFF);
        push_run(255, 8'h00);
        push_escape(ESC_END_OF_LINE);
        push_delta(2, 1);
        push_absolute(3);
        push_end_of_bitmap();

        // rle4 with odd start offset: nibble pairs, single trailing nibble,
        // spans outside the image
        configure(1, 5, 2, 0, 1);
        push_start();
        push_run(5, 8'hA5);
        push_absolute(5);
        push_delta(255, 255);
        push_run(1, 8'h3C);
        push_end_of_bitmap();

        // tall image: full-length span ending on the last column, bottom-up
        // flip far from row zero, spans past the right edge
        configure(0, 260, 65535, 1, 0);
        push_start();
        push_delta(5, 255);
        push_run(255, 8'h5A);
        push_run(1, 8'hC3);
        repeat (3) push_delta(255, 255);
        push_run(4, 8'h11);
        push_absolute(3);
        push_escape(ESC_END_OF_LINE);
        push_run(2, 8'h77);
        push_end_of_bitmap();

        random_items = 0;
        for (int p = 0; random_items < RANDOM_ITEMS; p++) begin
            if (p == 0)
                configure($urandom_range(0, 1), 65535, 65535, $urandom_range(0, 1),
                          $urandom_range(0, 1));
            else if (p == 1)
                configure($urandom_range(0, 1), 0, 0, $urandom_range(0, 1),
                          $urandom_range(0, 1));
            else
                configure($urandom_range(0, 1), pick_dim(40), pick_dim(24),
                          $urandom_range(0, 1), $urandom_range(0, 1));
            random_image($urandom_range(20, 60));
        end

        wait_drained();
        $display("%0d input transactions over %0d register settings", items_accepted,
                 settings_used);
        $display("%0d span transactions checked, %0d end of image, %0d with range error",
                 spans_checked, eoi_seen, error_spans);
        if (mismatches == 0 && span_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d spans never arrived", mismatches, span_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
